// ----- hdl/sgr_pkg.sv -----
// ----------------------------------------------------------------------------
// sgr_pkg
// shared types and constants for the sgr attribute change encoder
// ----------------------------------------------------------------------------
package sgr_pkg;

   localparam int AttrWidth = 29;

   localparam logic [7:0] ChEsc  = 8'h1B;
   localparam logic [7:0] ChLbr  = 8'h5B;
   localparam logic [7:0] ChSemi = 8'h3B;
   localparam logic [7:0] ChM    = 8'h6D;

   localparam logic CsrAixterm = 1'b0;
   localparam logic CsrIso     = 1'b1;

   // which byte the datapath drives
   typedef enum logic [2:0] {
      SelEsc, SelLbr, SelSemi, SelHun, SelTen, SelOne, SelM
   } sgr_sel_type;

   // command from controller to datapath
   typedef struct packed {
      logic        load;    // latch new and old attribute, start a transaction
      logic        start;   // arm the parameter slots
      logic        retire;  // current parameter fully sent
      sgr_sel_type sel;     // byte to drive
   } sgr_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic       empty;  // changed attribute with no bytes
      logic       any;    // parameter slots pending
      logic       rest;   // slots pending beyond the current one
      logic       hun;    // current parameter has a hundreds digit
      logic       ten;    // current parameter has a tens digit
      logic [7:0] byte_v;
   } sgr_sts_type;

endpackage

// ----- hdl/sgr_datapath.sv -----
// ----------------------------------------------------------------------------
// sgr_datapath
// holds the attribute, works out the parameter slots and drives each byte
// ----------------------------------------------------------------------------
module sgr_datapath import sgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [AttrWidth-1:0] new_attr,
   input  logic                 aix_en,
   input  logic                 iso_en,
   input  sgr_cmd_type          cmd,
   output sgr_sts_type          sts,
   output logic                 changed
);

   // fixed slot order: per pair off, on2, on1; singles; fg code, 5, index;
   // bg code, 5, index
   localparam int Slots = 21;

   // parameter codes as three bcd digits
   localparam logic [3:0][11:0] PairOff   = {12'h025, 12'h024, 12'h023, 12'h022};
   localparam logic [3:0][11:0] PairOn1   = {12'h005, 12'h004, 12'h003, 12'h001};
   localparam logic [3:0][11:0] PairOn2   = {12'h006, 12'h021, 12'h020, 12'h002};
   localparam logic [2:0][11:0] SingleOn  = {12'h009, 12'h008, 12'h007};
   localparam logic [2:0][11:0] SingleOff = {12'h029, 12'h028, 12'h027};

   logic [AttrWidth-1:0] cur_ff, old_ff;
   logic                 aix_ff, iso_ff;
   logic [Slots-1:0]     pend_ff, pend_in;
   logic [Slots-1:0]     slot_en;
   logic [11:0]          slot_bcd [Slots];
   logic [Slots-1:0]     pick;
   logic [11:0]          num;

   // 8-bit index to bcd by compare and subtract
   function automatic logic [11:0] to_bcd(logic [7:0] v);
      logic [3:0] h, t;
      logic [7:0] r, rem;
      h = (v >= 8'd200) ? 4'd2 : (v >= 8'd100) ? 4'd1 : 4'd0;
      r = (v >= 8'd200) ? v - 8'd200 : (v >= 8'd100) ? v - 8'd100 : v;
      t = 4'd0;
      for (int i = 1; i < 10; i++) begin
         if (r >= 8'(10 * i)) t = 4'(i);
      end
      rem = r - ({4'd0, t} << 3) - ({4'd0, t} << 1);
      return {h, t, rem[3:0]};
   endfunction

   assign changed = (new_attr != cur_ff);

   always_comb begin
      logic [AttrWidth-1:0] nw, od;
      logic b1, b2, o1, o2, chg, rem;
      logic sn, so, low, aixm, isom;
      logic [7:0] cn, co;
      nw = cur_ff;
      od = old_ff;
      slot_en = '0;
      for (int i = 0; i < Slots; i++) slot_bcd[i] = '0;
      for (int k = 0; k < 4; k++) begin
         b1 = nw[18+2*k]; b2 = nw[19+2*k];
         o1 = od[18+2*k]; o2 = od[19+2*k];
         chg = ({b1, b2} != {o1, o2});
         rem = (o1 & ~b1) | (o2 & ~b2);
         slot_en[3*k]   = chg & rem;
         slot_en[3*k+1] = chg & (rem ? b2 : (b2 & ~o2));
         slot_en[3*k+2] = chg & (rem ? b1 : (b1 & ~o1));
         slot_bcd[3*k]   = PairOff[k];
         slot_bcd[3*k+1] = PairOn2[k];
         slot_bcd[3*k+2] = PairOn1[k];
      end
      for (int k = 0; k < 3; k++) begin
         slot_en[12+k]  = nw[26+k] ^ od[26+k];
         slot_bcd[12+k] = nw[26+k] ? SingleOn[k] : SingleOff[k];
      end
      for (int c = 0; c < 2; c++) begin
         sn = nw[16+c]; so = od[16+c];
         cn = sn ? nw[8*c +: 8] : 8'd0;
         co = so ? od[8*c +: 8] : 8'd0;
         chg  = !(sn == so && cn == co);
         low  = sn && (cn < 8'd8);
         aixm = sn && !low && (cn < 8'd16) && aix_ff;
         isom = sn && !low && !aixm && iso_ff;
         slot_en[15+3*c] = chg;
         slot_en[16+3*c] = chg & isom;
         slot_en[17+3*c] = chg & isom;
         if (low) begin
            slot_bcd[15+3*c] = {4'd0, 4'(3 + c), 1'b0, cn[2:0]};
         end else if (aixm) begin
            slot_bcd[15+3*c] = (c == 0) ? {4'd0, 4'd9, 1'b0, cn[2:0]}
                                        : {4'd1, 4'd0, 1'b0, cn[2:0]};
         end else if (isom) begin
            slot_bcd[15+3*c] = {4'd0, 4'(3 + c), 4'd8};
         end else begin
            slot_bcd[15+3*c] = {4'd0, 4'(3 + c), 4'd9};
         end
         slot_bcd[16+3*c] = 12'h005;
         slot_bcd[17+3*c] = to_bcd(cn);
      end
      // an all-zero attribute is a bare reset sequence
      if (nw == '0) slot_en = '0;
   end

   // lowest pending slot is the one being sent
   assign pick = pend_ff & (~pend_ff + 1'b1);

   always_comb begin
      num = '0;
      for (int i = 0; i < Slots; i++) begin
         if (pick[i]) num = num | slot_bcd[i];
      end
   end

   always_comb begin
      if (cmd.start) begin
         pend_in = slot_en;
      end else if (cmd.retire) begin
         pend_in = pend_ff & ~pick;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff  <= '0;
         old_ff  <= '0;
         aix_ff  <= 1'b1;
         iso_ff  <= 1'b1;
         pend_ff <= '0;
      end else begin
         if (cmd.load) begin
            old_ff <= cur_ff;
            cur_ff <= new_attr;
            aix_ff <= aix_en;
            iso_ff <= iso_en;
         end
         pend_ff <= pend_in;
      end
   end

   assign sts.empty = (slot_en == '0) && (cur_ff != '0);
   assign sts.any   = (pend_ff != '0);
   assign sts.rest  = ((pend_ff & ~pick) != '0);
   assign sts.hun   = (num[11:8] != 4'd0);
   assign sts.ten   = (num[7:4] != 4'd0);

   always_comb begin
      case (cmd.sel)
         SelEsc:  sts.byte_v = ChEsc;
         SelLbr:  sts.byte_v = ChLbr;
         SelSemi: sts.byte_v = ChSemi;
         SelHun:  sts.byte_v = {4'h3, num[11:8]};
         SelTen:  sts.byte_v = {4'h3, num[7:4]};
         SelOne:  sts.byte_v = {4'h3, num[3:0]};
         SelM:    sts.byte_v = ChM;
         default: sts.byte_v = ChM;
      endcase
   end

endmodule

// ----- hdl/sgr_controller.sv -----
// ----------------------------------------------------------------------------
// sgr_controller
// sequences load, byte output and completion
// ----------------------------------------------------------------------------
module sgr_controller import sgr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        changed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_last,
   output sgr_cmd_type cmd,
   input  sgr_sts_type sts
);

   typedef enum logic [3:0] {IDLE, CHECK, ESC, LBR, SEP, HUN, TEN, ONE, TERM} state_type;
   state_type state_ff;
   state_type digit_st;
   logic      take;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = state_ff inside {ESC, LBR, SEP, HUN, TEN, ONE, TERM};
   assign rsp_last  = (state_ff == TERM);
   assign take      = rsp_valid && !rsp_stall;
   // first digit of the current parameter, leading zeros skipped
   assign digit_st  = sts.hun ? HUN : (sts.ten ? TEN : ONE);

   always_comb begin
      cmd.load   = (state_ff == IDLE) && req_valid && changed;
      cmd.start  = (state_ff == CHECK);
      cmd.retire = (state_ff == ONE) && take;
      case (state_ff)
         ESC:     cmd.sel = SelEsc;
         LBR:     cmd.sel = SelLbr;
         SEP:     cmd.sel = SelSemi;
         HUN:     cmd.sel = SelHun;
         TEN:     cmd.sel = SelTen;
         ONE:     cmd.sel = SelOne;
         default: cmd.sel = SelM;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         case (state_ff)
            IDLE:    if (cmd.load) state_ff <= CHECK;
            CHECK:   state_ff <= sts.empty ? IDLE : ESC;
            ESC:     if (take) state_ff <= LBR;
            LBR:     if (take) state_ff <= sts.any ? digit_st : TERM;
            SEP:     if (take) state_ff <= digit_st;
            HUN:     if (take) state_ff <= TEN;
            TEN:     if (take) state_ff <= ONE;
            ONE:     if (take) state_ff <= sts.rest ? SEP : TERM;
            TERM:    if (take) state_ff <= IDLE;
            default: state_ff <= IDLE;
         endcase
      end
   end

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !rsp_valid) else $error("load while sending");
   a_check_next: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !rsp_valid && req_stall) else $error("check skipped");
   a_send_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !sts.empty) else $error("send with empty buffer");

endmodule

// ----- hdl/sgr_attribute_change_encoder.sv -----
// ----------------------------------------------------------------------------
// sgr_attribute_change_encoder
// emits the sgr escape bytes that turn the last attribute into the new one
// ----------------------------------------------------------------------------
// after an accepted transaction the check state comes before the first byte
// throughput: one byte per cycle while rsp_stall is low; a new request is taken only after the last byte
// a changed attribute with no visible effect passes through the check state and emits nothing
// an unchanged attribute is accepted in idle and emits nothing
// reset: synchronous; attribute cleared, aixterm and iso colour enabled
module sgr_attribute_change_encoder import sgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [AttrWidth-1:0] req_new_attribute,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_index,
   input  logic                 csr_data
);

   logic aix_ff, iso_ff;
   sgr_cmd_type cmd;
   sgr_sts_type sts;
   logic changed;

   // configuration registers, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         aix_ff <= 1'b1;
         iso_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            CsrAixterm: aix_ff <= csr_data;
            CsrIso:     iso_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   sgr_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .changed,
      .rsp_valid, .rsp_stall, .rsp_last, .cmd, .sts
   );

   // the datapath takes a copy of the colour settings with each transaction
   sgr_datapath u_dp (
      .clock, .reset, .new_attr(req_new_attribute), .aix_en(aix_ff),
      .iso_en(iso_ff), .cmd, .sts, .changed
   );

   assign rsp_out_byte = sts.byte_v;

endmodule
